FILE: src/apt_pkg.sv
// Shared types and constants for the affine point transform.
package apt_pkg;

    // Vertex coordinate width and coefficient fraction width.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_BITS  = 8 + FRAC_BITS;
    localparam int OUT_BITS   = 16;

    // Derived internal widths.
    localparam int PROD_BITS   = COORD_BITS + COEF_BITS;
    localparam int SIMPLE_BITS = COORD_BITS + 1;
    localparam int SUM_BITS    = PROD_BITS + 2;
    localparam int QUOT_BITS   = SUM_BITS - FRAC_BITS;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_OFFSET_X    = 3'd1;
    localparam logic [2:0] CFG_OFFSET_Y    = 3'd2;
    localparam logic [2:0] CFG_COEF_FIRST  = 3'd3;
    localparam logic [2:0] CFG_COEF_SECOND = 3'd4;

    typedef enum logic [2:0] {
        MODE_REFLECT_X = 3'd0,
        MODE_REFLECT_Y = 3'd1,
        MODE_TRANSLATE = 3'd2,
        MODE_ROTATE    = 3'd3,
        MODE_SCALE     = 3'd4,
        MODE_SHEAR     = 3'd5
    } t_mode;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_in;
        logic signed [COORD_BITS-1:0] y_in;
        logic                         last_point;
    } t_point_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x_out;
        logic signed [OUT_BITS-1:0] y_out;
        logic                       last_out;
        logic                       clipped;
    } t_point_out;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic  valid;
        logic  last;
        t_mode mode;
    } t_stage_ctl;

endpackage

FILE: src/apt_mult.sv
// First pipeline stage: the four coefficient products and the simple-mode results.
module apt_mult (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  apt_pkg::t_point_in                    i_item,
    input  apt_pkg::t_mode                        i_mode,
    input  logic signed [apt_pkg::COORD_BITS-1:0] i_offset_x,
    input  logic signed [apt_pkg::COORD_BITS-1:0] i_offset_y,
    input  logic signed [apt_pkg::COEF_BITS-1:0]  i_coef_first,
    input  logic signed [apt_pkg::COEF_BITS-1:0]  i_coef_second,
    output apt_pkg::t_stage_ctl                   o_ctl,
    output logic signed [apt_pkg::PROD_BITS-1:0]  o_pa,
    output logic signed [apt_pkg::PROD_BITS-1:0]  o_pb,
    output logic signed [apt_pkg::PROD_BITS-1:0]  o_pc,
    output logic signed [apt_pkg::PROD_BITS-1:0]  o_pd,
    output logic signed [apt_pkg::SIMPLE_BITS-1:0] o_sx,
    output logic signed [apt_pkg::SIMPLE_BITS-1:0] o_sy
);
    import apt_pkg::*;

    t_stage_ctl                    r_ctl;
    logic signed [PROD_BITS-1:0]   r_pa, r_pb, r_pc, r_pd;
    logic signed [PROD_BITS-1:0]   n_pa, n_pb, n_pc, n_pd;
    logic signed [SIMPLE_BITS-1:0] r_sx, r_sy, n_sx, n_sy;
    logic signed [SIMPLE_BITS-1:0] w_x, w_y;

    assign w_x = SIMPLE_BITS'(i_item.x_in);
    assign w_y = SIMPLE_BITS'(i_item.y_in);

    always_comb begin
        n_pa = PROD_BITS'(w_x) * PROD_BITS'(i_coef_first);
        n_pb = PROD_BITS'(w_y) * PROD_BITS'(i_coef_second);
        n_pc = PROD_BITS'(w_x) * PROD_BITS'(i_coef_second);
        n_pd = PROD_BITS'(w_y) * PROD_BITS'(i_coef_first);
        n_sx = w_x;
        n_sy = w_y;
        case (i_mode)
            MODE_REFLECT_X: n_sy = -w_y;
            MODE_REFLECT_Y: n_sx = -w_x;
            MODE_TRANSLATE: begin
                n_sx = w_x + SIMPLE_BITS'(i_offset_x);
                n_sy = w_y + SIMPLE_BITS'(i_offset_y);
            end
            default: begin
                n_sx = w_x;
                n_sy = w_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_valid;
        end
        r_ctl.last <= i_item.last_point;
        r_ctl.mode <= i_mode;
        r_pa <= n_pa;
        r_pb <= n_pb;
        r_pc <= n_pc;
        r_pd <= n_pd;
        r_sx <= n_sx;
        r_sy <= n_sy;
    end

    assign o_ctl = r_ctl;
    assign o_pa  = r_pa;
    assign o_pb  = r_pb;
    assign o_pc  = r_pc;
    assign o_pd  = r_pd;
    assign o_sx  = r_sx;
    assign o_sy  = r_sy;

endmodule

FILE: src/apt_combine.sv
// Second pipeline stage: exact fixed-point sums, with rounding half added for rotate and scale.
module apt_combine (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  apt_pkg::t_stage_ctl                    i_ctl,
    input  logic signed [apt_pkg::PROD_BITS-1:0]   i_pa,
    input  logic signed [apt_pkg::PROD_BITS-1:0]   i_pb,
    input  logic signed [apt_pkg::PROD_BITS-1:0]   i_pc,
    input  logic signed [apt_pkg::PROD_BITS-1:0]   i_pd,
    input  logic signed [apt_pkg::SIMPLE_BITS-1:0] i_sx,
    input  logic signed [apt_pkg::SIMPLE_BITS-1:0] i_sy,
    output apt_pkg::t_stage_ctl                    o_ctl,
    output logic signed [apt_pkg::SUM_BITS-1:0]    o_tx,
    output logic signed [apt_pkg::SUM_BITS-1:0]    o_ty
);
    import apt_pkg::*;

    localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1) <<< (FRAC_BITS - 1);

    t_stage_ctl                 r_ctl;
    logic signed [SUM_BITS-1:0] r_tx, r_ty, n_tx, n_ty;
    logic signed [SUM_BITS-1:0] w_pa, w_pb, w_pc, w_pd, w_sx, w_sy;

    assign w_pa = SUM_BITS'(i_pa);
    assign w_pb = SUM_BITS'(i_pb);
    assign w_pc = SUM_BITS'(i_pc);
    assign w_pd = SUM_BITS'(i_pd);
    assign w_sx = SUM_BITS'(i_sx) <<< FRAC_BITS;
    assign w_sy = SUM_BITS'(i_sy) <<< FRAC_BITS;

    always_comb begin
        case (i_ctl.mode)
            MODE_ROTATE: begin
                n_tx = w_pa - w_pb + HALF;
                n_ty = w_pc + w_pd + HALF;
            end
            MODE_SCALE: begin
                n_tx = w_pa + HALF;
                n_ty = w_pb + HALF;
            end
            MODE_SHEAR: begin
                n_tx = w_sx + w_pd;
                n_ty = w_sy;
            end
            default: begin
                // Simple modes carry an exact integer, so truncation keeps it.
                n_tx = w_sx;
                n_ty = w_sy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.last <= i_ctl.last;
        r_ctl.mode <= i_ctl.mode;
        r_tx <= n_tx;
        r_ty <= n_ty;
    end

    assign o_ctl = r_ctl;
    assign o_tx  = r_tx;
    assign o_ty  = r_ty;

endmodule

FILE: src/apt_round_sat.sv
// Third pipeline stage: truncation toward zero and 16-bit saturation.
module apt_round_sat (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  apt_pkg::t_stage_ctl                 i_ctl,
    input  logic signed [apt_pkg::SUM_BITS-1:0] i_tx,
    input  logic signed [apt_pkg::SUM_BITS-1:0] i_ty,
    output logic                                o_valid,
    output apt_pkg::t_point_out                 o_result
);
    import apt_pkg::*;

    localparam logic signed [QUOT_BITS-1:0] OUT_MAX = QUOT_BITS'(32767);
    localparam logic signed [QUOT_BITS-1:0] OUT_MIN = QUOT_BITS'(-32768);

    logic                       r_valid;
    t_point_out                 r_result, n_result;
    logic signed [QUOT_BITS-1:0] w_qx, w_qy;
    logic                       w_clip_x, w_clip_y;

    // Arithmetic shift rounds toward minus infinity; a negative value with a
    // nonzero fraction is bumped up by one to round toward zero.
    function automatic logic signed [QUOT_BITS-1:0] trunc_zero(
        input logic signed [SUM_BITS-1:0] t
    );
        logic signed [QUOT_BITS-1:0] q;
        q = t[SUM_BITS-1:FRAC_BITS];
        if (t[SUM_BITS-1] && (t[FRAC_BITS-1:0] != '0)) begin
            q = q + QUOT_BITS'(1);
        end
        return q;
    endfunction

    always_comb begin
        w_qx = trunc_zero(i_tx);
        w_qy = trunc_zero(i_ty);
        w_clip_x = (w_qx > OUT_MAX) || (w_qx < OUT_MIN);
        w_clip_y = (w_qy > OUT_MAX) || (w_qy < OUT_MIN);
        if (w_qx > OUT_MAX) begin
            n_result.x_out = OUT_MAX[OUT_BITS-1:0];
        end else if (w_qx < OUT_MIN) begin
            n_result.x_out = OUT_MIN[OUT_BITS-1:0];
        end else begin
            n_result.x_out = w_qx[OUT_BITS-1:0];
        end
        if (w_qy > OUT_MAX) begin
            n_result.y_out = OUT_MAX[OUT_BITS-1:0];
        end else if (w_qy < OUT_MIN) begin
            n_result.y_out = OUT_MIN[OUT_BITS-1:0];
        end else begin
            n_result.y_out = w_qy[OUT_BITS-1:0];
        end
        n_result.last_out = i_ctl.last;
        n_result.clipped  = w_clip_x || w_clip_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: src/affine_point_transform.sv
// Top level of the affine point transform: configuration registers and pipeline.
//
// One polygon vertex enters per item on i_item when i_start is high and
// o_busy is low. o_busy is always low: the pipeline takes an item in every
// clock cycle, so a full stream runs at one item per cycle.
// The vertex is reflected, translated, rotated, scaled or sheared according
// to the mode register, rounded as the mode demands and saturated to 16-bit
// signed. The result shows on o_result with o_done high for exactly one
// cycle. Products, sums, then rounding with saturation each take one
// register stage.
// Results leave in input order. The receiver cannot stall the block, so
// every result must be taken in the cycle it is shown.
// Configuration goes through i_cfg_we, i_cfg_idx and i_cfg_data and takes
// effect at once; write it only while no item is in flight. Indexes above
// four are ignored.
// Synchronous reset drops any item in flight and loads mode reflect-x,
// zero offsets, a first coefficient of one and a second coefficient of zero.
module affine_point_transform (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  apt_pkg::t_point_in                   i_item,
    output logic                                 o_done,
    output apt_pkg::t_point_out                  o_result,
    input  logic                                 i_cfg_we,
    input  logic [2:0]                           i_cfg_idx,
    input  logic [apt_pkg::COEF_BITS-1:0]        i_cfg_data
);
    import apt_pkg::*;

    t_mode                         r_mode;
    logic signed [COORD_BITS-1:0]  r_offset_x;
    logic signed [COORD_BITS-1:0]  r_offset_y;
    logic signed [COEF_BITS-1:0]   r_coef_first;
    logic signed [COEF_BITS-1:0]   r_coef_second;

    t_stage_ctl                    w_ctl1, w_ctl2;
    logic signed [PROD_BITS-1:0]   w_pa, w_pb, w_pc, w_pd;
    logic signed [SIMPLE_BITS-1:0] w_sx, w_sy;
    logic signed [SUM_BITS-1:0]    w_tx, w_ty;

    // Configuration registers. Only the low bits of each register's width
    // are kept from the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_REFLECT_X;
            r_offset_x    <= '0;
            r_offset_y    <= '0;
            r_coef_first  <= COEF_BITS'(1) << FRAC_BITS;
            r_coef_second <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:        r_mode        <= t_mode'(i_cfg_data[2:0]);
                CFG_OFFSET_X:    r_offset_x    <= i_cfg_data[COORD_BITS-1:0];
                CFG_OFFSET_Y:    r_offset_y    <= i_cfg_data[COORD_BITS-1:0];
                CFG_COEF_FIRST:  r_coef_first  <= i_cfg_data;
                CFG_COEF_SECOND: r_coef_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline never holds an item back.
    assign o_busy = 1'b0;

    apt_mult u_mult (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_start && !o_busy),
        .i_item        (i_item),
        .i_mode        (r_mode),
        .i_offset_x    (r_offset_x),
        .i_offset_y    (r_offset_y),
        .i_coef_first  (r_coef_first),
        .i_coef_second (r_coef_second),
        .o_ctl         (w_ctl1),
        .o_pa          (w_pa),
        .o_pb          (w_pb),
        .o_pc          (w_pc),
        .o_pd          (w_pd),
        .o_sx          (w_sx),
        .o_sy          (w_sy)
    );

    apt_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl1),
        .i_pa    (w_pa),
        .i_pb    (w_pb),
        .i_pc    (w_pc),
        .i_pd    (w_pd),
        .i_sx    (w_sx),
        .i_sy    (w_sy),
        .o_ctl   (w_ctl2),
        .o_tx    (w_tx),
        .o_ty    (w_ty)
    );

    apt_round_sat u_round_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl2),
        .i_tx     (w_tx),
        .i_ty     (w_ty),
        .o_valid  (o_done),
        .o_result (o_result)
    );

endmodule

FILE: src/apt_checker.sv
// Port-level checker for the affine point transform and its bind.
module apt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input apt_pkg::t_point_in            i_item,
    input logic                          o_done,
    input apt_pkg::t_point_out           o_result
);
    import apt_pkg::*;

    // Every accepted item comes out on o_done after passing the full pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_done)
        else $error("accepted item did not produce a result on time");

    // No result without a matching item accepted out of reset.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_start, 3) && !$past(o_busy, 3) && $past(i_rst_n, 3)))
        else $error("result without a matching item");

    // The last-vertex flag travels with its item.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.last_out == $past(i_item.last_point, 3)))
        else $error("last-vertex flag does not match its item");

    // A clipped result has at least one coordinate at a saturation limit.
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.clipped) |->
            (o_result.x_out == 16'sh7FFF || o_result.x_out == 16'sh8000 ||
             o_result.y_out == 16'sh7FFF || o_result.y_out == 16'sh8000))
        else $error("clipped set but no coordinate at a limit");

endmodule

bind affine_point_transform apt_checker u_apt_checker (.*);
